// ----- src/bilinear_rgb565_letterbox_scaler_defines.svh -----
// ----------------------------------------------------------------------------
// Bilinear RGB565 letterbox scaler: assertion macros
// Shared property forms for the checker. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_RGB565_LETTERBOX_SCALER_DEFINES_SVH
`define BILINEAR_RGB565_LETTERBOX_SCALER_DEFINES_SVH

// Same-cycle implication.
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear RGB565 letterbox scaler: package
// Field widths, register codes, reset values and blend constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

    // Payload widths
    localparam int POS_W      = 9;
    localparam int COLOR_W    = 16;
    localparam int SRC_DIM_W  = 9;
    localparam int DEST_DIM_W = 10;
    localparam int OFFSET_W   = 9;
    localparam int STEP_W     = 24;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y      = 3'd7;

    // Register reset values
    localparam logic [SRC_DIM_W-1:0]  SRC_WIDTH_RST   = 9'd184;
    localparam logic [SRC_DIM_W-1:0]  SRC_HEIGHT_RST  = 9'd184;
    localparam logic [DEST_DIM_W-1:0] DEST_WIDTH_RST  = 10'd368;
    localparam logic [DEST_DIM_W-1:0] DEST_HEIGHT_RST = 10'd368;
    localparam logic [OFFSET_W-1:0]   OFFSET_X_RST    = 9'd0;
    localparam logic [OFFSET_W-1:0]   OFFSET_Y_RST    = 9'd0;
    localparam logic [STEP_W-1:0]     STEP_X_RST      = 24'd32768;
    localparam logic [STEP_W-1:0]     STEP_Y_RST      = 24'd32768;

    // Coordinate mapping: offset * step is 17.16, fraction taken at bit 11
    localparam int FP_W       = POS_W + STEP_W;
    localparam int FP_INT_LSB = 16;
    localparam int FP_INT_W   = FP_W - FP_INT_LSB;
    localparam int FRAC_W     = 5;
    localparam int FRAC_LSB   = 11;
    localparam int WGT_W      = FRAC_W + 1;
    localparam logic [WGT_W-1:0] FRAC_ONE = 6'd32;

    // Blend
    localparam logic [COLOR_W-1:0] MASK_RB = 16'hF81F;
    localparam logic [COLOR_W-1:0] MASK_G  = 16'h07E0;
    localparam int BLEND_SHIFT = 10;

    // Output queue, also the bound on reads in flight
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int CRED_W         = $clog2(OUT_FIFO_DEPTH + 1);

    // Parameter defaults
    localparam int DEF_MAX_SRC_W = 256;
    localparam int DEF_MAX_SRC_H = 256;
    localparam int DEF_PANEL_W   = 512;
    localparam int DEF_PANEL_H   = 512;

endpackage

`default_nettype wire

// ----- src/bls_if.sv -----
// ----------------------------------------------------------------------------
// Bilinear RGB565 letterbox scaler: channel interfaces
// Valid/ready channels for request beats and pixel result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bls_in_if import bls_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] color_in;

    modport source (output valid, op, pos_x, pos_y, color_in, input ready);
    modport sink (input valid, op, pos_x, pos_y, color_in, output ready);
endinterface

interface bls_out_if import bls_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_out;

    modport source (output valid, color_out, input ready);
    modport sink (input valid, color_out, output ready);
endinterface

`default_nettype wire

// ----- src/bilinear_rgb565_letterbox_scaler.sv -----
// A read beat gives its pixel via the output queue after stage 5; writes give no beat.
// Throughput: one beat per cycle while ready is high, reads and writes mixed freely.
// Up to 8 reads may be unreturned; ready drops while the 8-entry output queue is committed.
// The frame sits in two row-parity banks, each read at both neighbour columns in the same cycle.
// Reset: registers take their defaults and the pipeline empties; frame memory is not cleared.
// ----------------------------------------------------------------------------
// Bilinear RGB565 letterbox scaler
// Stores a source frame and returns bilinear-scaled pixels at panel coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilinear_rgb565_letterbox_scaler import bls_pkg::*; #(
    parameter int MAX_SRC_W = DEF_MAX_SRC_W,
    parameter int MAX_SRC_H = DEF_MAX_SRC_H,
    parameter int PANEL_W   = DEF_PANEL_W,
    parameter int PANEL_H   = DEF_PANEL_H
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bls_in_if.sink                     pix_in,
    bls_out_if.source                  pix_out,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW      = $clog2(MAX_SRC_W);
    localparam int YW      = $clog2(MAX_SRC_H);
    localparam int SWW     = $clog2(MAX_SRC_W + 1);
    localparam int SHW     = $clog2(MAX_SRC_H + 1);
    localparam int HALF_H  = (MAX_SRC_H + 1) / 2;
    localparam int BANK_DEPTH = HALF_H * MAX_SRC_W;
    localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CMP_W   = 12;
    localparam int TRB_W   = 21;
    localparam int TG_W    = 16;
    localparam int VRB_W   = TRB_W + BLEND_SHIFT - 5;
    localparam int VG_W    = TG_W + BLEND_SHIFT - 5;
    localparam int G_OUT_W = VG_W - BLEND_SHIFT;
    localparam int FIFO_AW = $clog2(OUT_FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SRC_DIM_W-1:0]  src_width_reg, src_height_reg;
    logic [DEST_DIM_W-1:0] dest_width_reg, dest_height_reg;
    logic [OFFSET_W-1:0]   offset_x_reg, offset_y_reg;
    logic [STEP_W-1:0]     step_x_reg, step_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= SRC_WIDTH_RST;
            src_height_reg  <= SRC_HEIGHT_RST;
            dest_width_reg  <= DEST_WIDTH_RST;
            dest_height_reg <= DEST_HEIGHT_RST;
            offset_x_reg    <= OFFSET_X_RST;
            offset_y_reg    <= OFFSET_Y_RST;
            step_x_reg      <= STEP_X_RST;
            step_y_reg      <= STEP_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:   src_width_reg   <= cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT:  src_height_reg  <= cfg_data[SRC_DIM_W-1:0];
                CFG_DEST_WIDTH:  dest_width_reg  <= cfg_data[DEST_DIM_W-1:0];
                CFG_DEST_HEIGHT: dest_height_reg <= cfg_data[DEST_DIM_W-1:0];
                CFG_OFFSET_X:    offset_x_reg    <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_Y:    offset_y_reg    <= cfg_data[OFFSET_W-1:0];
                CFG_STEP_X:      step_x_reg      <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:      step_y_reg      <= cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective source size: zero acts as one, clamp to the frame store
    logic [SWW-1:0] src_w_eff;
    logic [SHW-1:0] src_h_eff;

    always_comb
    begin
        if (src_width_reg == '0)
            src_w_eff = SWW'(1);
        else if (CMP_W'(src_width_reg) > CMP_W'(MAX_SRC_W))
            src_w_eff = SWW'(MAX_SRC_W);
        else
            src_w_eff = SWW'(src_width_reg);

        if (src_height_reg == '0)
            src_h_eff = SHW'(1);
        else if (CMP_W'(src_height_reg) > CMP_W'(MAX_SRC_H))
            src_h_eff = SHW'(MAX_SRC_H);
        else
            src_h_eff = SHW'(src_height_reg);
    end

    // ------------------------------------------------------------------
    // Credit count and handshake
    // ------------------------------------------------------------------
    logic [CRED_W-1:0] cred_reg, cred_next;
    logic              in_acc, rd_acc, out_pop;

    assign pix_in.ready = (cred_reg < CRED_W'(OUT_FIFO_DEPTH));
    assign in_acc  = pix_in.valid && pix_in.ready;
    assign rd_acc  = in_acc && (pix_in.op == OP_READ);
    assign out_pop = pix_out.valid && pix_out.ready;

    always_comb
    begin
        cred_next = cred_reg;
        if (rd_acc && !out_pop)
            cred_next = cred_reg + 1'b1;
        else if (!rd_acc && out_pop)
            cred_next = cred_reg - 1'b1;
    end

    // ------------------------------------------------------------------
    // Stage 1: window test, panel offset, write decode
    // ------------------------------------------------------------------
    logic               s1_inside, s1_wok;
    logic [POS_W-1:0]   s1_dx, s1_dy;

    always_comb
    begin
        s1_dx = pix_in.pos_x - offset_x_reg;
        s1_dy = pix_in.pos_y - offset_y_reg;
        s1_inside = (CMP_W'(pix_in.pos_x) < CMP_W'(PANEL_W))
                 && (CMP_W'(pix_in.pos_y) < CMP_W'(PANEL_H))
                 && (pix_in.pos_x >= offset_x_reg)
                 && (pix_in.pos_y >= offset_y_reg)
                 && (DEST_DIM_W'(s1_dx) < dest_width_reg)
                 && (DEST_DIM_W'(s1_dy) < dest_height_reg);
        // Drop writes outside the frame store
        s1_wok = (CMP_W'(pix_in.pos_x) < CMP_W'(MAX_SRC_W))
              && (CMP_W'(pix_in.pos_y) < CMP_W'(MAX_SRC_H));
    end

    logic               s1_rd_reg, s1_wen_reg, s1_in_reg;
    logic [POS_W-1:0]   s1_dx_reg, s1_dy_reg;
    logic [XW-1:0]      s1_wx_reg;
    logic [YW-1:0]      s1_wy_reg;
    logic [COLOR_W-1:0] s1_wcol_reg;

    // Stage 2: 17.16 source coordinates
    logic               s2_rd_reg, s2_wen_reg, s2_in_reg;
    logic [FP_W-1:0]    s2_fpx_reg, s2_fpy_reg;
    logic [XW-1:0]      s2_wx_reg;
    logic [YW-1:0]      s2_wy_reg;
    logic [COLOR_W-1:0] s2_wcol_reg;

    // Stage 3: clamped neighbour indices, memory access
    logic               s3_rd_reg, s3_wen_reg, s3_in_reg;
    logic [XW-1:0]      s3_x0_reg, s3_x1_reg, s3_wx_reg;
    logic [YW-1:0]      s3_y0_reg, s3_y1_reg, s3_wy_reg;
    logic [FRAC_W-1:0]  s3_fx_reg, s3_fy_reg;
    logic [COLOR_W-1:0] s3_wcol_reg;

    // Stage 4: bank read data
    logic               s4_rd_reg, s4_in_reg;
    logic               s4_y0b_reg, s4_y1b_reg;
    logic [FRAC_W-1:0]  s4_fx_reg, s4_fy_reg;
    logic [COLOR_W-1:0] bank_rd_reg [4];

    // Stage 5: horizontal blend
    logic               s5_rd_reg, s5_in_reg;
    logic [TRB_W-1:0]   s5_trb_reg, s5_brb_reg;
    logic [TG_W-1:0]    s5_tg_reg, s5_bg_reg;
    logic [FRAC_W-1:0]  s5_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cred_reg   <= '0;
            s1_rd_reg  <= 1'b0;
            s1_wen_reg <= 1'b0;
            s2_rd_reg  <= 1'b0;
            s2_wen_reg <= 1'b0;
            s3_rd_reg  <= 1'b0;
            s3_wen_reg <= 1'b0;
            s4_rd_reg  <= 1'b0;
            s5_rd_reg  <= 1'b0;
        end
        else
        begin
            cred_reg   <= cred_next;
            s1_rd_reg  <= rd_acc;
            s1_wen_reg <= in_acc && (pix_in.op == OP_WRITE) && s1_wok;
            s2_rd_reg  <= s1_rd_reg;
            s2_wen_reg <= s1_wen_reg;
            s3_rd_reg  <= s2_rd_reg;
            s3_wen_reg <= s2_wen_reg;
            s4_rd_reg  <= s3_rd_reg;
            s5_rd_reg  <= s4_rd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 axis mapping
    // ------------------------------------------------------------------
    logic [FP_INT_W-1:0] ipx, ipy;
    logic [XW-1:0]       x0, x1;
    logic [YW-1:0]       y0, y1;

    always_comb
    begin
        ipx = s2_fpx_reg[FP_W-1:FP_INT_LSB];
        ipy = s2_fpy_reg[FP_W-1:FP_INT_LSB];
        // Saturate to the last column/row; the right/lower neighbour then repeats
        if (ipx >= FP_INT_W'(src_w_eff))
            x0 = XW'(src_w_eff - 1'b1);
        else
            x0 = XW'(ipx);
        if ((SWW'(x0) + 1'b1) < src_w_eff)
            x1 = x0 + 1'b1;
        else
            x1 = x0;

        if (ipy >= FP_INT_W'(src_h_eff))
            y0 = YW'(src_h_eff - 1'b1);
        else
            y0 = YW'(ipy);
        if ((SHW'(y0) + 1'b1) < src_h_eff)
            y1 = y0 + 1'b1;
        else
            y1 = y0;
    end

    // ------------------------------------------------------------------
    // Stage 4 neighbour selection and horizontal blend
    // ------------------------------------------------------------------
    function automatic logic [COLOR_W-1:0] pick_bank(
        input logic sy, input logic sx,
        input logic [COLOR_W-1:0] r0, input logic [COLOR_W-1:0] r1,
        input logic [COLOR_W-1:0] r2, input logic [COLOR_W-1:0] r3);
        logic [COLOR_W-1:0] sel;
        case ({sy, sx})
            2'b00:   sel = r0;
            2'b01:   sel = r1;
            2'b10:   sel = r2;
            default: sel = r3;
        endcase
        return sel;
    endfunction

    logic [COLOR_W-1:0] p00, p01, p10, p11;
    logic [WGT_W-1:0]   wfx, wifx;
    logic [TRB_W-1:0]   h_trb, h_brb;
    logic [TG_W-1:0]    h_tg, h_bg;

    always_comb
    begin
        // Each row bank returns the left column in its first slot, the right in its second
        p00 = pick_bank(s4_y0b_reg, 1'b0, bank_rd_reg[0], bank_rd_reg[1],
                        bank_rd_reg[2], bank_rd_reg[3]);
        p01 = pick_bank(s4_y0b_reg, 1'b1, bank_rd_reg[0], bank_rd_reg[1],
                        bank_rd_reg[2], bank_rd_reg[3]);
        p10 = pick_bank(s4_y1b_reg, 1'b0, bank_rd_reg[0], bank_rd_reg[1],
                        bank_rd_reg[2], bank_rd_reg[3]);
        p11 = pick_bank(s4_y1b_reg, 1'b1, bank_rd_reg[0], bank_rd_reg[1],
                        bank_rd_reg[2], bank_rd_reg[3]);
        wfx  = WGT_W'(s4_fx_reg);
        wifx = FRAC_ONE - wfx;
        h_trb = TRB_W'(p00 & MASK_RB) * TRB_W'(wifx) + TRB_W'(p01 & MASK_RB) * TRB_W'(wfx);
        h_brb = TRB_W'(p10 & MASK_RB) * TRB_W'(wifx) + TRB_W'(p11 & MASK_RB) * TRB_W'(wfx);
        h_tg  = TG_W'(p00 & MASK_G) * TG_W'(wifx) + TG_W'(p01 & MASK_G) * TG_W'(wfx);
        h_bg  = TG_W'(p10 & MASK_G) * TG_W'(wifx) + TG_W'(p11 & MASK_G) * TG_W'(wfx);
    end

    // ------------------------------------------------------------------
    // Stage 5 vertical blend
    // ------------------------------------------------------------------
    logic [WGT_W-1:0]   wfy, wify;
    logic [VRB_W-1:0]   v_rb;
    logic [VG_W-1:0]    v_g;
    logic [COLOR_W-1:0] pix_rb, pix_g, pix_res;

    always_comb
    begin
        wfy  = WGT_W'(s5_fy_reg);
        wify = FRAC_ONE - wfy;
        v_rb = VRB_W'(s5_trb_reg) * VRB_W'(wify) + VRB_W'(s5_brb_reg) * VRB_W'(wfy);
        v_g  = VG_W'(s5_tg_reg) * VG_W'(wify) + VG_W'(s5_bg_reg) * VG_W'(wfy);
        pix_rb = v_rb[BLEND_SHIFT +: COLOR_W];
        pix_g  = COLOR_W'(v_g[BLEND_SHIFT +: G_OUT_W]);
        pix_res = s5_in_reg ? ((pix_rb & MASK_RB) | (pix_g & MASK_G)) : '0;
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_in_reg   <= s1_inside;
        s1_dx_reg   <= s1_dx;
        s1_dy_reg   <= s1_dy;
        s1_wx_reg   <= XW'(pix_in.pos_x);
        s1_wy_reg   <= YW'(pix_in.pos_y);
        s1_wcol_reg <= pix_in.color_in;

        s2_in_reg   <= s1_in_reg;
        s2_fpx_reg  <= FP_W'(s1_dx_reg) * FP_W'(step_x_reg);
        s2_fpy_reg  <= FP_W'(s1_dy_reg) * FP_W'(step_y_reg);
        s2_wx_reg   <= s1_wx_reg;
        s2_wy_reg   <= s1_wy_reg;
        s2_wcol_reg <= s1_wcol_reg;

        s3_in_reg   <= s2_in_reg;
        s3_x0_reg   <= x0;
        s3_x1_reg   <= x1;
        s3_y0_reg   <= y0;
        s3_y1_reg   <= y1;
        s3_fx_reg   <= s2_fpx_reg[FRAC_LSB +: FRAC_W];
        s3_fy_reg   <= s2_fpy_reg[FRAC_LSB +: FRAC_W];
        s3_wx_reg   <= s2_wx_reg;
        s3_wy_reg   <= s2_wy_reg;
        s3_wcol_reg <= s2_wcol_reg;

        s4_in_reg   <= s3_in_reg;
        s4_y0b_reg  <= s3_y0_reg[0];
        s4_y1b_reg  <= s3_y1_reg[0];
        s4_fx_reg   <= s3_fx_reg;
        s4_fy_reg   <= s3_fy_reg;

        s5_in_reg   <= s4_in_reg;
        s5_trb_reg  <= h_trb;
        s5_brb_reg  <= h_brb;
        s5_tg_reg   <= h_tg;
        s5_bg_reg   <= h_bg;
        s5_fy_reg   <= s4_fy_reg;
    end

    // ------------------------------------------------------------------
    // Frame store: two banks split by row parity, each read at both
    // neighbour columns. Reads and writes both access the banks from
    // stage 3, one beat per edge in acceptance order, so a read always
    // sees every earlier write.
    // ------------------------------------------------------------------
    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [YW-1:0] row, input logic [XW-1:0] col);
        return BANK_AW'(row >> 1) * BANK_AW'(MAX_SRC_W) + BANK_AW'(col);
    endfunction

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        localparam logic BY = 1'(b);

        logic [COLOR_W-1:0] mem [BANK_DEPTH];
        logic [YW-1:0]      row;
        logic [BANK_AW-1:0] raddr0, raddr1, waddr;
        logic               wen;

        always_comb
        begin
            row    = (s3_y0_reg[0] == BY) ? s3_y0_reg : s3_y1_reg;
            raddr0 = bank_addr(row, s3_x0_reg);
            raddr1 = bank_addr(row, s3_x1_reg);
            waddr  = bank_addr(s3_wy_reg, s3_wx_reg);
            wen    = s3_wen_reg && (s3_wy_reg[0] == BY);
        end

        always_ff @(posedge clk)
        begin
            if (wen)
                mem[waddr] <= s3_wcol_reg;
            bank_rd_reg[2*b]   <= mem[raddr0];
            bank_rd_reg[2*b+1] <= mem[raddr1];
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] fifo_mem [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CRED_W-1:0]  fifo_cnt_reg, fifo_cnt_next;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (s5_rd_reg && !out_pop)
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        else if (!s5_rd_reg && out_pop)
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (s5_rd_reg)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_rd_reg)
            fifo_mem[wr_ptr_reg] <= pix_res;
    end

    assign pix_out.valid     = (fifo_cnt_reg != '0);
    assign pix_out.color_out = fifo_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- src/bls_checker.sv -----
// ----------------------------------------------------------------------------
// Bilinear RGB565 letterbox scaler: port checker
// Tracks unreturned reads on the ports and checks the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_rgb565_letterbox_scaler_defines.svh"

module bls_checker import bls_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               in_op,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [COLOR_W-1:0] out_color
);

    logic [CRED_W-1:0] pend_reg, pend_next;
    logic              rd_beat, out_beat;

    assign rd_beat  = in_valid && in_ready && (in_op == OP_READ);
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (rd_beat && !out_beat)
            pend_next = pend_reg + 1'b1;
        else if (!rd_beat && out_beat)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // A stalled result beat holds its pixel
    `BLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_color), "result beat changed while stalled")

    // Every result beat answers an earlier read
    `BLS_ASSERT_NOW(a_no_orphan, out_valid, pend_reg != '0,
        "result beat with no read outstanding")

    // Reads in flight never exceed the output queue
    `BLS_ASSERT_NOW(a_pend_bound, 1'b1, pend_reg <= CRED_W'(OUT_FIFO_DEPTH),
        "more reads outstanding than queue entries")

    // Backpressure only when the queue is fully committed
    `BLS_ASSERT_NOW(a_ready_cause, !in_ready, pend_reg == CRED_W'(OUT_FIFO_DEPTH),
        "ready low with queue space left")

endmodule

bind bilinear_rgb565_letterbox_scaler bls_checker u_bls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .in_op     (pix_in.op),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_color (pix_out.color_out)
);

`default_nettype wire
